@@ hdl/lpg_pkg.sv @@
// Shared types and constants for the line pixel generator.
// Holds coordinate widths, the sequencer states and the control structs.
// No dependencies.
`default_nettype none

package lpg_pkg;

   // Coordinate width; derived widths follow from it
   localparam int COORD_BITS = 6;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int ACC_BITS   = COORD_BITS + 2;
   localparam int COLOR_BITS = 32;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_RAW_BITS  = 4 * COORD_BITS + COLOR_BITS;
   localparam int REQ_DATA_BITS = ((REQ_RAW_BITS + 7) / 8) * 8;
   localparam int RSP_RAW_BITS  = 2 * COORD_BITS + COLOR_BITS;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [DELTA_BITS-1:0] delta_type;   // two's complement
   typedef logic [ACC_BITS-1:0]   acc_type;     // two's complement
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

   // Sequencer to datapath
   typedef struct packed {
      logic load_cmd;
      logic do_setup;
      logic do_step;
   } ctrl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic at_end;
   } status_type;

   // Result of one pass through the step unit
   typedef struct packed {
      acc_type   acc;
      coord_type minor;
   } step_type;

endpackage

`default_nettype wire

@@ hdl/lpg_step_unit.sv @@
// Shared add/compare unit: one error-accumulator update per use.
// Depends on lpg_pkg.
`default_nettype none

module lpg_step_unit (
   input  wire lpg_pkg::acc_type   acc_i,
   input  wire lpg_pkg::delta_type delta_i,
   input  wire lpg_pkg::coord_type span_i,
   input  wire lpg_pkg::coord_type minor_i,
   output lpg_pkg::step_type       step_o
);

   logic signed [lpg_pkg::ACC_BITS-1:0] sum;
   logic signed [lpg_pkg::ACC_BITS-1:0] span_s;

   // Add the minor delta, then fold the remainder back into [0, span)
   always_comb begin
      sum    = $signed(acc_i) + $signed({delta_i[lpg_pkg::DELTA_BITS-1], delta_i});
      span_s = $signed({2'b00, span_i});
      step_o.acc   = lpg_pkg::acc_type'(sum);
      step_o.minor = minor_i;
      if (!delta_i[lpg_pkg::DELTA_BITS-1]) begin
         if (sum >= span_s) begin
            step_o.acc   = lpg_pkg::acc_type'(sum - span_s);
            step_o.minor = minor_i + lpg_pkg::coord_type'(1);
         end
      end else begin
         if (sum < $signed(lpg_pkg::acc_type'(0))) begin
            step_o.acc   = lpg_pkg::acc_type'(sum + span_s);
            step_o.minor = minor_i - lpg_pkg::coord_type'(1);
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/lpg_ctrl.sv @@
// Sequencer for the line pixel generator: idle, setup, pixel run.
// Depends on lpg_pkg.
`default_nettype none

module lpg_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   input  wire lpg_pkg::status_type status_i,
   output lpg_pkg::ctrl_type      ctrl_o
);

   lpg_pkg::state_type state_ff;
   lpg_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpg_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = lpg_pkg::ST_SETUP;
         end
         lpg_pkg::ST_SETUP: begin
            state_in = lpg_pkg::ST_RUN;
         end
         lpg_pkg::ST_RUN: begin
            if (rsp_tready && status_i.at_end) state_in = lpg_pkg::ST_IDLE;
         end
         default: state_in = lpg_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready      = 1'b0;
      rsp_tvalid      = 1'b0;
      ctrl_o.load_cmd = 1'b0;
      ctrl_o.do_setup = 1'b0;
      ctrl_o.do_step  = 1'b0;
      unique case (state_ff)
         lpg_pkg::ST_IDLE: begin
            req_tready      = 1'b1;
            ctrl_o.load_cmd = req_tvalid;
         end
         lpg_pkg::ST_SETUP: begin
            ctrl_o.do_setup = 1'b1;
         end
         lpg_pkg::ST_RUN: begin
            rsp_tvalid     = 1'b1;
            ctrl_o.do_step = rsp_tready && !status_i.at_end;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/lpg_path.sv @@
// Datapath for the line pixel generator: command latch, setup and pixel state.
// Depends on lpg_pkg and lpg_step_unit.
`default_nettype none

module lpg_path (
   input  wire                    clock,
   input  wire lpg_pkg::ctrl_type ctrl_i,
   input  wire lpg_pkg::coord_type start_x_i,
   input  wire lpg_pkg::coord_type start_y_i,
   input  wire lpg_pkg::coord_type end_x_i,
   input  wire lpg_pkg::coord_type end_y_i,
   input  wire lpg_pkg::color_type pen_color_i,
   output lpg_pkg::coord_type     pixel_x_o,
   output lpg_pkg::coord_type     pixel_y_o,
   output lpg_pkg::color_type     pixel_color_o,
   output lpg_pkg::status_type    status_o
);

   // Latched command
   lpg_pkg::coord_type ax_ff, ay_ff, bx_ff, by_ff;
   lpg_pkg::color_type held_color_ff;

   // Line state
   lpg_pkg::coord_type major_pos_ff, major_pos_in;
   lpg_pkg::coord_type major_end_ff, major_end_in;
   lpg_pkg::coord_type minor_pos_ff, minor_pos_in;
   lpg_pkg::coord_type major_span_ff, major_span_in;
   lpg_pkg::delta_type minor_delta_ff, minor_delta_in;
   lpg_pkg::acc_type   error_acc_ff, error_acc_in;
   logic               steep_flag_ff, steep_flag_in;

   // Setup terms
   lpg_pkg::coord_type adx, ady, maj0, min0, maj1, min1;
   lpg_pkg::step_type  step;

   lpg_step_unit u_step (
      .acc_i   (error_acc_ff),
      .delta_i (minor_delta_ff),
      .span_i  (major_span_ff),
      .minor_i (minor_pos_ff),
      .step_o  (step)
   );

   // Pick the major axis and order endpoints so the major coordinate rises
   always_comb begin
      adx = (ax_ff >= bx_ff) ? (ax_ff - bx_ff) : (bx_ff - ax_ff);
      ady = (ay_ff >= by_ff) ? (ay_ff - by_ff) : (by_ff - ay_ff);
      steep_flag_in = (adx < ady);
      if (steep_flag_in) begin
         maj0 = ay_ff; min0 = ax_ff; maj1 = by_ff; min1 = bx_ff;
      end else begin
         maj0 = ax_ff; min0 = ay_ff; maj1 = bx_ff; min1 = by_ff;
      end
      if (maj0 > maj1) begin
         maj0 = maj1;
         min0 = min1;
         maj1 = steep_flag_in ? ay_ff : ax_ff;
         min1 = steep_flag_in ? ax_ff : ay_ff;
      end
   end

   // Next values of the line state
   always_comb begin
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      major_span_in  = major_span_ff;
      minor_delta_in = minor_delta_ff;
      error_acc_in   = error_acc_ff;
      priority if (ctrl_i.do_setup) begin
         major_pos_in   = maj0;
         major_end_in   = maj1;
         minor_pos_in   = min0;
         major_span_in  = maj1 - maj0;
         minor_delta_in = {1'b0, min1} - {1'b0, min0};
         error_acc_in   = '0;
      end else if (ctrl_i.do_step) begin
         major_pos_in = major_pos_ff + lpg_pkg::coord_type'(1);
         minor_pos_in = step.minor;
         error_acc_in = step.acc;
      end else begin
         // hold the line state
      end
   end

   // Hold the command and advance the line state
   always_ff @(posedge clock) begin
      if (ctrl_i.load_cmd) begin
         ax_ff         <= start_x_i;
         ay_ff         <= start_y_i;
         bx_ff         <= end_x_i;
         by_ff         <= end_y_i;
         held_color_ff <= pen_color_i;
      end
      if (ctrl_i.do_setup) steep_flag_ff <= steep_flag_in;
      major_pos_ff   <= major_pos_in;
      major_end_ff   <= major_end_in;
      minor_pos_ff   <= minor_pos_in;
      major_span_ff  <= major_span_in;
      minor_delta_ff <= minor_delta_in;
      error_acc_ff   <= error_acc_in;
   end

   // Swap the axes back for steep lines
   assign pixel_x_o       = steep_flag_ff ? minor_pos_ff : major_pos_ff;
   assign pixel_y_o       = steep_flag_ff ? major_pos_ff : minor_pos_ff;
   assign pixel_color_o   = held_color_ff;
   assign status_o.at_end = (major_pos_ff == major_end_ff);

endmodule

`default_nettype wire

@@ hdl/line_pixel_generator.sv @@
// Line pixel generator top level: rasterizes one line request into pixels.
// Depends on lpg_pkg, lpg_ctrl, lpg_path and lpg_step_unit.
//
//   channel   direction   payload
//   req_      in          start_x, start_y, end_x, end_y, pen_color
//   rsp_      out         pixel_x, pixel_y, pixel_color; tlast = last_pixel
//
// A request is taken while idle and then set up; after that the run state gives
// span + 1 pixels, span being the major-axis length (0..63), one pixel a cycle
// while rsp_tready is high, from the shared error-accumulator add/compare unit.
// req_tready is high only while idle. A stalled rsp_ holds the pixel and the
// line state. Reset is synchronous and returns the sequencer to idle.
`default_nettype none

module line_pixel_generator (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // start_x, start_y, end_x, end_y, pen_color (lowest bit up)
   input  wire  [lpg_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // pixel_x, pixel_y, pixel_color, zero pad (lowest bit up)
   output logic [lpg_pkg::RSP_DATA_BITS-1:0]     rsp_tdata,
   output logic                                  rsp_tlast
);

   lpg_pkg::ctrl_type   ctrl;
   lpg_pkg::status_type status;
   lpg_pkg::coord_type  pixel_x, pixel_y;
   lpg_pkg::color_type  pixel_color;

   lpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status_i   (status),
      .ctrl_o     (ctrl)
   );

   lpg_path u_path (
      .clock         (clock),
      .ctrl_i        (ctrl),
      .start_x_i     (req_tdata[0 +: lpg_pkg::COORD_BITS]),
      .start_y_i     (req_tdata[lpg_pkg::COORD_BITS +: lpg_pkg::COORD_BITS]),
      .end_x_i       (req_tdata[2*lpg_pkg::COORD_BITS +: lpg_pkg::COORD_BITS]),
      .end_y_i       (req_tdata[3*lpg_pkg::COORD_BITS +: lpg_pkg::COORD_BITS]),
      .pen_color_i   (req_tdata[4*lpg_pkg::COORD_BITS +: lpg_pkg::COLOR_BITS]),
      .pixel_x_o     (pixel_x),
      .pixel_y_o     (pixel_y),
      .pixel_color_o (pixel_color),
      .status_o      (status)
   );

   // Pack the pixel
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[lpg_pkg::RSP_RAW_BITS-1:0] = {pixel_color, pixel_y, pixel_x};
   end
   assign rsp_tlast = status.at_end;

`ifndef SYNTH
   // Never take a request while a line is still being drawn
   assert property (@(posedge clock) disable iff (reset) !(req_tready && rsp_tvalid))
      else $error("request taken while pixels pending");

   // An accepted request is followed by setup, with the input closed and no pixel offered
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (!req_tready && !rsp_tvalid))
      else $error("accepted request did not enter setup");

   // Setup is followed by the first pixel
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |=> rsp_tvalid)
      else $error("no pixel after setup");

   // The last pixel taken ends the line
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && !rsp_tvalid))
      else $error("line did not end after last pixel");
`endif

endmodule

`default_nettype wire
